// ===== hdl/lru_pkg.sv =====
`default_nettype none

package lru_pkg;

  localparam int FRAMES  = 8;
  localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int PAGE_W  = 16;
  localparam int CFG_W   = 8;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(8);

  // byte address of the frame limit register on the config port
  localparam logic [1:0] ACTIVE_FRAMES_ADDR = 2'd0;

  // one slot of the recency chain: a frame and the page it holds
  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [PAGE_W-1:0]  page;
  } entry_t;

  // effective frame count: zero acts as one, large values clamp to the build size
  function automatic logic [CNT_W-1:0] limit_frames(input logic [CFG_W-1:0] raw);
    logic [CNT_W-1:0] lim;
    if (raw == '0) begin
      lim = CNT_W'(1);
    end else if (32'(raw) > 32'(FRAMES)) begin
      lim = CNT_W'(FRAMES);
    end else begin
      lim = CNT_W'(raw);
    end
    return lim;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lru_page_replacement.sv =====
`default_nettype none

// LRU page replacement unit. Each input item is one page access (page_id); each
// access yields exactly one result item: fault, the frame that holds the page
// afterwards, and on a replacement the evicted page. The recency order lives in
// a chain of FRAMES cells, most recent first; each cell holds a frame number and
// the page in that frame. An access first takes the item in S_IDLE; then, in
// S_UPDATE, every cell compares its page with the key and the chain shifts right
// up to the hit (or fill / victim) position while the new front entry enters at
// cell 0. The update waits while the previous result still sits unread in the
// output register, so a slow consumer stretches the time per item. The
// active_frames register (address 0) limits how many frames fill; zero acts as
// one and values above the build size clamp. Lowering it frees no frame. No
// clearing pass follows reset: frame contents are only read once filled.
module lru_page_replacement
  import lru_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // access channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [PAGE_W-1:0] page_id,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   fault,
  output logic [2:0]             frame,
  output logic                   evicted_valid,
  output logic [15:0]            evicted_page,
  // register port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [1:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  fill_count;
  logic [CFG_W-1:0]  active_frames;
  logic [PAGE_W-1:0] key;

  // chain signals
  entry_t            cell_entry [FRAMES];
  entry_t            cell_left  [FRAMES];
  logic [FRAMES-1:0] cell_shift;
  logic [FRAMES-1:0] cell_match;
  logic [FRAMES-1:0] cell_valid;
  logic [FRAMES-1:0] hit;
  logic [FRAMES-1:0] tail;     // one-hot: last filled cell

  // decision
  logic               hit_any;
  logic [CNT_W-1:0]   hit_pos;
  logic [FRAME_W-1:0] hit_frame;
  logic [FRAME_W-1:0] tail_frame;
  logic [PAGE_W-1:0]  tail_page;
  logic               do_fill;
  logic [CNT_W-1:0]   sel_pos;
  logic [FRAME_W-1:0] sel_frame;
  logic               update_go;
  logic               cfg_write;

  // ---------------------------------------------------------------------------
  // register port: one register, every write lands on it
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == ACTIVE_FRAMES_ADDR) ?
                     {{(32-CFG_W){1'b0}}, active_frames} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_frames <= ACTIVE_RESET;
    end else if (cfg_write) begin
      active_frames <= pwdata[CFG_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // chain of cells
  // ---------------------------------------------------------------------------
  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      if (g == 0) begin : g_head
        // new most recent entry enters at the head
        assign cell_left[g] = '{frame: sel_frame, page: key};
      end else begin : g_body
        assign cell_left[g] = cell_entry[g-1];
      end

      assign cell_valid[g] = (CNT_W'(g) < fill_count);
      assign hit[g]        = cell_match[g] && cell_valid[g];
      assign cell_shift[g] = update_go && (CNT_W'(g) <= sel_pos);

      if (g == FRAMES - 1) begin : g_last
        assign tail[g] = cell_valid[g];
      end else begin : g_mid
        assign tail[g] = cell_valid[g] && !cell_valid[g+1];
      end

      lru_cell u_cell (
        .clk   (clk),
        .shift (cell_shift[g]),
        .left  (cell_left[g]),
        .key   (key),
        .entry (cell_entry[g]),
        .match (cell_match[g])
      );
    end
  endgenerate

  // pages in the chain are distinct, so at most one cell hits
  always_comb begin
    hit_any    = 1'b0;
    hit_pos    = '0;
    hit_frame  = '0;
    tail_frame = '0;
    tail_page  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (hit[i]) begin
        hit_any = 1'b1;
        hit_pos = CNT_W'(i);
      end
      hit_frame  = hit_frame  | (hit[i]  ? cell_entry[i].frame : '0);
      tail_frame = tail_frame | (tail[i] ? cell_entry[i].frame : '0);
      tail_page  = tail_page  | (tail[i] ? cell_entry[i].page  : '0);
    end
  end

  // hit: move it up; free frame left: fill at the tail; else evict the tail
  assign do_fill = !hit_any && (fill_count < limit_frames(active_frames));

  always_comb begin
    if (hit_any) begin
      sel_pos   = hit_pos;
      sel_frame = hit_frame;
    end else if (do_fill) begin
      sel_pos   = fill_count;
      sel_frame = FRAME_W'(fill_count);
    end else begin
      sel_pos   = fill_count - CNT_W'(1);
      sel_frame = tail_frame;
    end
  end

  // ---------------------------------------------------------------------------
  // control: take an item, then update once the result register is free
  // ---------------------------------------------------------------------------
  assign in_ready  = (state == S_IDLE);
  assign update_go = (state == S_UPDATE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (update_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (update_go) begin
        out_valid <= 1'b1;
        if (do_fill) begin
          fill_count <= fill_count + CNT_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      key <= page_id;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (update_go) begin
      fault         <= !hit_any;
      frame         <= 3'(sel_frame);
      evicted_valid <= !hit_any && !do_fill;
      evicted_page  <= (!hit_any && !do_fill) ? 16'(tail_page) : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(FRAMES))
    else $error("fill count beyond frame count");

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |-> ($countones(hit) <= 1))
    else $error("page held in more than one frame");

  a_take_then_update: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_UPDATE))
    else $error("accepted item not processed");

  a_evict_is_fault: assert property (@(posedge clk) disable iff (rst)
    (out_valid && evicted_valid) |-> fault)
    else $error("eviction reported without fault");

  a_fill_step: assert property (@(posedge clk) disable iff (rst || $past(rst))
    (fill_count != $past(fill_count)) |-> (fill_count == $past(fill_count) + CNT_W'(1)))
    else $error("fill count moved by more than one");

endmodule

`default_nettype wire

// ===== hdl/lru_cell.sv =====
`default_nettype none

module lru_cell
  import lru_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              shift,
  input  wire entry_t            left,
  input  wire logic [PAGE_W-1:0] key,
  output entry_t                 entry,
  output logic                   match
);

  entry_t slot;

  // take the neighbor's entry when the chain moves through this slot
  always_ff @(posedge clk) begin
    if (shift) begin
      slot <= left;
    end
  end

  assign entry = slot;
  assign match = (slot.page == key);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
  import lru_pkg::*;

  // an input stall with no handshake anywhere for this long ends the run
  localparam int STALL_LIMIT = 3000;
  // the output side stops taking results for this long once, to back up the block
  localparam int HOLD_CYCLES = 150;
  localparam int HOLD_AT_RESULT = 300;
  localparam int MAX_REPORTS = 200;

  // one expected result item, fields as the block reports them
  typedef struct packed {
    logic              fault;
    logic [2:0]        frame;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
  } access_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [15:0]       page_id = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              fault;
  logic [2:0]        frame;
  logic              evicted_valid;
  logic [15:0]       evicted_page;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [1:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // page accesses waiting to be offered, and results owed by the block
  logic [15:0]       page_queue[$];
  access_result_t    owed_results[$];
  int                pages_queued = 0;
  int                results_seen = 0;
  int                errors = 0;
  // when set, neither side idles
  bit                calm = 1'b0;

  // shadow of the block's state: page per frame, recency order, fill level, limit
  logic [PAGE_W-1:0]  held_page[FRAMES];
  logic [FRAME_W-1:0] recency[FRAMES];
  int                 frames_filled = 0;
  logic [CFG_W-1:0]   active_raw = ACTIVE_RESET;

  lru_page_replacement uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page_id       (page_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fault         (fault),
    .frame         (frame),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk = ~clk;

  // apply one page access to the shadow state and return what the block must report
  function automatic access_result_t predict_access(input logic [PAGE_W-1:0] pg);
    access_result_t     r;
    int                 hit_pos;
    int                 lim;
    int                 slot;
    logic [FRAME_W-1:0] fr;
    r = '0;
    hit_pos = -1;
    // search only filled frames, most recent first
    for (int i = 0; i < frames_filled; i++) begin
      if (hit_pos < 0 && held_page[recency[i]] == pg) hit_pos = i;
    end
    // zero acts as one frame, anything past the build size clamps
    if (active_raw == '0) lim = 1;
    else if (int'(active_raw) > FRAMES) lim = FRAMES;
    else lim = int'(active_raw);
    if (hit_pos >= 0) begin
      slot = hit_pos;
      fr = recency[slot];
    end else if (frames_filled < lim) begin
      // free frame left: fill frames in index order
      r.fault = 1'b1;
      fr = FRAME_W'(frames_filled);
      held_page[fr] = pg;
      slot = frames_filled;
      frames_filled++;
    end else begin
      // full (or limit lowered below fill level): replace least recent of all filled
      r.fault = 1'b1;
      slot = frames_filled - 1;
      fr = recency[slot];
      r.evicted_valid = 1'b1;
      r.evicted_page = held_page[fr];
      held_page[fr] = pg;
    end
    // every access leaves its frame at the front
    for (int i = slot; i > 0; i--) recency[i] = recency[i - 1];
    recency[0] = fr;
    r.frame = 3'(fr);
    return r;
  endfunction

  // sender: predict on acceptance, then offer the next queued access unless idling
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      page_id <= '0;
    end else begin
      if (in_valid && in_ready) owed_results.push_back(predict_access(page_id));
      if (!in_valid || in_ready) begin
        if (page_queue.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
          in_valid <= 1'b1;
          page_id <= page_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // result checker: each accepted result against the oldest owed one
  always @(posedge clk) begin
    access_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing owed: fault %h frame %h evicted %h page %h",
                   $time, fault, frame, evicted_valid, evicted_page);
      end else begin
        want = owed_results.pop_front();
        if (fault !== want.fault) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: fault expected %h actual %h", $time, want.fault, fault);
        end
        if (frame !== want.frame) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: frame expected %h actual %h", $time, want.frame, frame);
        end
        if (evicted_valid !== want.evicted_valid) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: evicted_valid expected %h actual %h", $time,
                     want.evicted_valid, evicted_valid);
        end
        if (evicted_page !== want.evicted_page) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: evicted_page expected %h actual %h", $time,
                     want.evicted_page, evicted_page);
        end
      end
    end
  end

  // watchdog: any handshake on either channel or the config port resets the count
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic queue_page(input logic [15:0] pg);
    page_queue.push_back(pg);
    pages_queued++;
  endtask

  // wait until every queued item has produced its result, then a short gap
  task automatic drain();
    wait (results_seen >= pages_queued);
    repeat (4) @(posedge clk);
  endtask

  // config write with the block idle: setup cycle, then access cycle
  task automatic set_active_frames(input logic [31:0] value);
    drain();
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ACTIVE_FRAMES_ADDR;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    active_raw = value[CFG_W-1:0];
  endtask

  // random accesses: mostly a small working set so hits and evictions mix,
  // the rest fully random pages that nearly always miss
  task automatic random_accesses(input int count);
    logic [15:0] working_set[16];
    int          set_size;
    set_size = $urandom_range(3, 14);
    for (int i = 0; i < 16; i++) working_set[i] = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) queue_page(16'($urandom));
      else queue_page(working_set[$urandom_range(set_size - 1)]);
    end
  endtask

  initial begin
    // limit per random phase: below, at and above the fill level, zero and clamped values
    int unsigned phase_limit[9] = '{2, 7, 3, 15, 1, 8, 9, 0, 6};
    int          phase_items[9] = '{200, 200, 200, 200, 200, 200, 200, 200, 183};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset limit of eight: three fills with extreme pages, then a hit at the back
    queue_page(16'h0000);
    queue_page(16'hFFFF);
    queue_page(16'h5555);
    queue_page(16'h0000);
    // zero acts as one frame, already below the fill level: misses evict, hits still hit
    set_active_frames(32'd0);
    queue_page(16'hAAAA);
    queue_page(16'h0000);
    queue_page(16'h5555);
    queue_page(16'h0001);
    // limit raised: filling resumes at the next unused frame, then eviction
    set_active_frames(32'd5);
    queue_page(16'h8000);
    queue_page(16'h7FFF);
    queue_page(16'h1234);
    queue_page(16'h8000);
    // far above the build size: clamps, two more fills then hits
    set_active_frames(32'd255);
    queue_page(16'h00FF);
    queue_page(16'hFF00);
    queue_page(16'h7FFF);
    queue_page(16'h00FF);
    queue_page(16'h1234);

    for (int p = 0; p < 9; p++) begin
      set_active_frames(phase_limit[p]);
      // one phase runs with no idling on either side
      calm = (p == 3);
      random_accesses(phase_items[p]);
    end

    drain();
    calm = 1'b0;
    repeat (10) @(posedge clk);
    if (owed_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, owed_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
